FILE: hw/rtl/psinv_pkg.sv
// Shared constants, status codes and multiplier request type for the power series inverse.
package psinv_pkg;

  localparam int DW      = 30;
  localparam int IW      = 10;
  localparam int SW      = 2;
  localparam int PW      = 2 * DW;
  localparam int QW      = 31;
  localparam int RW      = 32;
  localparam int MM_LAT  = 5;
  localparam int PEND_W  = 3;
  localparam int EXP_TOP = DW - 1;

  localparam logic [DW-1:0] MOD    = 30'd998244353;
  localparam logic [RW-1:0] MOD_R  = 32'd998244353;
  localparam logic [RW-1:0] MOD2_R = 32'd1996488706;
  localparam logic [DW-1:0] EXP    = MOD - 30'd2;

  localparam logic [63:0]   MU_FULL = (64'd1 << 60) / 64'd998244353;
  localparam logic [QW-1:0] MU      = MU_FULL[QW-1:0];

  localparam logic [SW-1:0] STAT_OK   = 2'd0;
  localparam logic [SW-1:0] STAT_ZERO = 2'd1;
  localparam logic [SW-1:0] STAT_OVER = 2'd2;

  typedef struct packed {
    logic          valid;
    logic [DW-1:0] x;
    logic [DW-1:0] y;
  } mm_req_t;

endpackage

FILE: hw/rtl/power_series_inverse_mod_prime.sv
// Top level: sequencer, coefficient stores and output register of the series inverse.
// Index 0: 30 squarings and 28 multiplies by the constant term,
//   each through the shared 5-stage modular multiplier.
// Index i >= 1: one product a cycle streamed from the two stores.
// Zero constant term or index of MAX_N or more: no multiplies. One transaction in work at a time.
// Synchronous rst clears control state; the stores are not cleared and need no pass.
module power_series_inverse_mod_prime #(
  parameter int MAX_N = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // coef[29:0], zero pad [31:30]
  input  logic [0:0]  s_axis_tuser,  // first[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // coef_out[29:0], index[39:30]
  output logic [1:0]  m_axis_tuser   // status[1:0]
);
  import psinv_pkg::*;

  localparam int CW = $clog2(MAX_N + 1);
  localparam int AW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam logic [CW-1:0] MAXC = CW'(MAX_N);

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b00000000001,
    ST_SQR    = 11'b00000000010,
    ST_SQR_W  = 11'b00000000100,
    ST_MULA   = 11'b00000001000,
    ST_MULA_W = 11'b00000010000,
    ST_SUM    = 11'b00000100000,
    ST_DRAIN  = 11'b00001000000,
    ST_FIN    = 11'b00010000000,
    ST_FIN_W  = 11'b00100000000,
    ST_DONE   = 11'b01000000000,
    ST_SPARE  = 11'b10000000000
  } state_t;

  state_t state, state_next;

  logic [CW-1:0]     count;
  logic [DW-1:0]     inv_const;
  logic [CW-1:0]     idx;
  logic [DW-1:0]     a_reg;
  logic [DW-1:0]     r;
  logic [4:0]        bitpos;
  logic [CW-1:0]     j;
  logic [DW-1:0]     acc;
  logic [PEND_W-1:0] pend;
  logic              rd_valid;
  logic [DW-1:0]     a_q;
  logic [DW-1:0]     b_q;
  logic [DW-1:0]     b_res;
  logic [SW-1:0]     stat_res;
  logic              store;
  logic              out_valid;
  logic [DW-1:0]     coef_out_q;
  logic [IW-1:0]     index_q;
  logic [SW-1:0]     status_q;

  logic [DW-1:0] a_mem [MAX_N];
  logic [DW-1:0] b_mem [MAX_N];

  logic          first_in;
  logic [DW-1:0] coef_in;
  logic [DW-1:0] a_in;
  logic [CW-1:0] idx_in;
  logic          ovf_in;
  logic          accept;
  logic          out_load;
  logic          issue;
  logic          retire;
  logic          bit_set;
  logic          last_bit;
  logic          pow_done;
  logic [DW:0]   acc_sum;
  logic [CW-1:0] bidx;

  mm_req_t       mm_req;
  logic          res_valid;
  logic [DW-1:0] res;

  psinv_mulmod u_mulmod (
    .clk       (clk),
    .rst       (rst),
    .req       (mm_req),
    .res_valid (res_valid),
    .res       (res)
  );

  assign first_in = s_axis_tuser[0];
  assign coef_in  = s_axis_tdata[DW-1:0];
  assign a_in     = (coef_in >= MOD) ? (coef_in - MOD) : coef_in;
  assign idx_in   = first_in ? '0 : count;
  assign ovf_in   = (idx_in >= MAXC);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_load = (state == ST_DONE) && (!out_valid || m_axis_tready);
  assign issue    = (state == ST_SUM);
  assign retire   = res_valid && ((state == ST_SUM) || (state == ST_DRAIN));
  assign bit_set  = EXP[bitpos];
  assign last_bit = (bitpos == '0);
  assign pow_done = res_valid && (((state == ST_SQR_W) && !bit_set && last_bit) ||
                                  ((state == ST_MULA_W) && last_bit));
  assign acc_sum  = {1'b0, acc} + {1'b0, res};
  assign bidx     = idx - j;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (ovf_in) begin
            state_next = ST_DONE;
          end else if (idx_in == '0) begin
            state_next = (a_in == '0) ? ST_DONE : ST_SQR;
          end else begin
            state_next = (inv_const == '0) ? ST_DONE : ST_SUM;
          end
        end
      end
      ST_SQR:    state_next = ST_SQR_W;
      ST_SQR_W: begin
        if (res_valid) begin
          if (bit_set) begin
            state_next = ST_MULA;
          end else begin
            state_next = last_bit ? ST_DONE : ST_SQR;
          end
        end
      end
      ST_MULA:   state_next = ST_MULA_W;
      ST_MULA_W: begin
        if (res_valid) begin
          state_next = last_bit ? ST_DONE : ST_SQR;
        end
      end
      ST_SUM:    state_next = (j == idx) ? ST_DRAIN : ST_SUM;
      ST_DRAIN:  state_next = (pend == '0) ? ST_FIN : ST_DRAIN;
      ST_FIN:    state_next = ST_FIN_W;
      ST_FIN_W: begin
        if (res_valid) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mm_req.valid = rd_valid;
    mm_req.x     = a_q;
    mm_req.y     = b_q;
    unique case (state)
      ST_SQR: begin
        mm_req.valid = 1'b1;
        mm_req.x     = r;
        mm_req.y     = r;
      end
      ST_MULA: begin
        mm_req.valid = 1'b1;
        mm_req.x     = r;
        mm_req.y     = a_reg;
      end
      ST_FIN: begin
        mm_req.valid = 1'b1;
        mm_req.x     = inv_const;
        mm_req.y     = acc;
      end
      default: begin
        mm_req.valid = rd_valid;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      inv_const <= '0;
      pend      <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= issue;
      pend     <= pend + PEND_W'(issue) - PEND_W'(retire);
      if (accept && !ovf_in && (idx_in == '0) && (a_in == '0)) begin
        inv_const <= '0;
      end else if (pow_done) begin
        inv_const <= res;
      end
      if (out_load && store) begin
        count <= idx + CW'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx    <= idx_in;
      a_reg  <= a_in;
      r      <= DW'(1);
      bitpos <= 5'(EXP_TOP);
      j      <= CW'(1);
      acc    <= '0;
      b_res  <= '0;
      if (ovf_in) begin
        stat_res <= STAT_OVER;
        store    <= 1'b0;
      end else if ((idx_in == '0) && (a_in == '0)) begin
        stat_res <= STAT_ZERO;
        store    <= 1'b1;
      end else if ((idx_in != '0) && (inv_const == '0)) begin
        stat_res <= STAT_ZERO;
        store    <= 1'b1;
      end else begin
        stat_res <= STAT_OK;
        store    <= 1'b1;
      end
    end
    if ((state == ST_SQR_W) && res_valid) begin
      r <= res;
      if (!bit_set && !last_bit) begin
        bitpos <= bitpos - 5'd1;
      end
    end
    if ((state == ST_MULA_W) && res_valid) begin
      r <= res;
      if (!last_bit) begin
        bitpos <= bitpos - 5'd1;
      end
    end
    if (pow_done) begin
      b_res <= res;
    end
    if (issue) begin
      j <= j + CW'(1);
    end
    if (retire) begin
      acc <= (acc_sum >= {1'b0, MOD}) ? DW'(acc_sum - {1'b0, MOD}) : acc_sum[DW-1:0];
    end
    if ((state == ST_FIN_W) && res_valid) begin
      b_res <= (res == '0) ? '0 : (MOD - res);
    end
    if (out_load) begin
      coef_out_q <= b_res;
      index_q    <= store ? IW'(idx) : '0;
      status_q   <= stat_res;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !ovf_in) begin
      a_mem[idx_in[AW-1:0]] <= a_in;
    end
    a_q <= a_mem[j[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (out_load && store) begin
      b_mem[idx[AW-1:0]] <= b_res;
    end
    b_q <= b_mem[bidx[AW-1:0]];
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {index_q, coef_out_q};
  assign m_axis_tuser  = status_q;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken again straight after a transaction");

  a_result_expected: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((state == ST_SQR_W) || (state == ST_MULA_W) || (state == ST_FIN_W) ||
                   (state == ST_SUM) || (state == ST_DRAIN)))
    else $error("multiplier result with no consumer");

  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    pend <= PEND_W'(MM_LAT + 1))
    else $error("too many products in flight");

  a_flagged_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && ((m_axis_tuser == STAT_ZERO) || (m_axis_tuser == STAT_OVER))) |->
      (m_axis_tdata[DW-1:0] == '0))
    else $error("flagged result carries a non-zero coefficient");

endmodule

FILE: hw/rtl/psinv_mulmod.sv
// Five-stage pipelined modular multiplier with Barrett reduction.
module psinv_mulmod (
  input  logic                   clk,
  input  logic                   rst,
  input  psinv_pkg::mm_req_t     req,
  output logic                   res_valid,
  output logic [psinv_pkg::DW-1:0] res
);
  import psinv_pkg::*;

  logic [MM_LAT-1:0] vld;
  logic [PW-1:0]     prod;
  logic [2*QW-1:0]   qt;
  logic [RW-1:0]     lo2;
  logic [RW-1:0]     lo3;
  logic [RW-1:0]     qm;
  logic [RW-1:0]     rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[MM_LAT-2:0], req.valid};
    end
  end

  always_ff @(posedge clk) begin
    prod <= PW'(req.x) * PW'(req.y);
    qt   <= (2*QW)'(prod[PW-1:DW-1]) * (2*QW)'(MU);
    lo2  <= prod[RW-1:0];
    qm   <= qt[2*QW-1:QW] * MOD_R;
    lo3  <= lo2;
    rem  <= lo3 - qm;
    if (rem >= MOD2_R) begin
      res <= DW'(rem - MOD2_R);
    end else if (rem >= MOD_R) begin
      res <= DW'(rem - MOD_R);
    end else begin
      res <= rem[DW-1:0];
    end
  end

  assign res_valid = vld[MM_LAT-1];

endmodule
